// File: hdl/iorb_pkg.sv
`default_nettype none

package iorb_pkg;

   // Fixed field widths of the sequence id and the batch count register.
   localparam int ID_W  = 6;
   localparam int CNT_W = 7;

   // Batch count after reset.
   localparam logic [CNT_W-1:0] BATCH_RESET = 7'd64;

   // Control states of the release sequencer.
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

// File: hdl/in_order_reorder_buffer.sv
// Reorder buffer that releases items strictly in sequence-id order.
// Input channel req_*: each transaction carries an item id and a value. An
// item whose id is the next one expected is passed to the output at once;
// a later id is parked in the holding RAM; an id outside the batch or one
// already released is dropped without a result.
// Result channel rsp_*: released items in id order. After an in-order item,
// every consecutive parked item follows, one per cycle while rsp_tready is high,
// and rsp_tlast marks the final result caused by that input transaction.
// Output: a released input item is registered and appears on rsp in the
// cycle after acceptance. Throughput: one input transaction per cycle while
// no run is draining and the output register can move. A drain run is paced
// by the single read port of the holding RAM; req_tready stays low until the
// run's last result is loaded into the output register.
// Configuration: csr_wr_en writes the batch count, restarts the batch and
// clears every parked entry; write only while the block is idle.
// Reset: next expected id returns to 0, all parked entries are invalid and
// the batch count is 64. No clearing pass is needed.
// Stall: a result waits in the output register while rsp_tready is low, and
// no new transaction is accepted until it can move.
`default_nettype none

module in_order_reorder_buffer
   import iorb_pkg::*;
#(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32,
   localparam int DATA_W     = ((ID_W + VALUE_WIDTH + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Input channel.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // item_id, item_value, zero fill
   // Result channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [DATA_W-1:0] rsp_tdata,   // out_id, out_value, zero fill
   output logic                   rsp_tlast,   // last_in_run
   // Batch count register.
   input  wire logic              csr_wr_en,
   input  wire logic [CNT_W-1:0]  csr_wdata
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       batch_ff, batch_in;
   logic [CNT_W-1:0]       next_exp_ff, next_exp_in;
   logic [DEPTH-1:0]       valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   req_fire;
   logic [CNT_W-1:0]       eff_count;
   logic [ID_W-1:0]        in_id;
   logic [CNT_W-1:0]       in_id_x;
   logic [VALUE_WIDTH-1:0] in_value;
   logic [CNT_W-1:0]       in_succ;
   logic                   in_more;
   logic [CNT_W-1:0]       dr_succ;
   logic                   dr_more;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   // Parked payloads. A read is issued only to start or continue a drain run, never
   // in a cycle that parks an item, so a read and a write never meet on the same entry.
   iorb_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (in_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Batch count limited to 1 to DEPTH, the range the store can hold.
   always_comb begin
      priority if (batch_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (batch_ff > CNT_W'(DEPTH)) begin
         eff_count = CNT_W'(DEPTH);
      end else begin
         eff_count = batch_ff;
      end
   end

   // Handshake and field unpacking.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign in_id      = req_tdata[ID_W-1:0];
   assign in_id_x    = CNT_W'(in_id);
   assign in_value   = req_tdata[ID_W +: VALUE_WIDTH];

   // Whether the run continues past the item being released.
   assign in_succ = in_id_x + CNT_W'(1);
   assign in_more = (in_succ < eff_count) && valid_ff[in_succ[ADDR_W-1:0]];
   assign dr_succ = next_exp_ff + CNT_W'(1);
   assign dr_more = (dr_succ < eff_count) && valid_ff[dr_succ[ADDR_W-1:0]];

   // Next state, store updates and output register loads.
   always_comb begin
      state_in     = state_ff;
      batch_in     = batch_ff;
      next_exp_in  = next_exp_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = in_id[ADDR_W-1:0];
      ram_rd_en    = 1'b0;
      ram_rd_addr  = in_succ[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (in_id_x >= eff_count || in_id_x < next_exp_ff) begin
                  // Outside the batch or already released: dropped.
               end else if (in_id_x != next_exp_ff) begin
                  // Early arrival: park it.
                  ram_wr_en                       = 1'b1;
                  valid_in[in_id[ADDR_W-1:0]]     = 1'b1;
               end else begin
                  // In order: release now and start a drain if the successor waits.
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = in_id;
                  rsp_value_in = in_value;
                  if (in_more) begin
                     rsp_last_in = 1'b0;
                     ram_rd_en   = 1'b1;
                     next_exp_in = in_succ;
                     state_in    = ST_DRAIN;
                  end else begin
                     rsp_last_in = 1'b1;
                     next_exp_in = (in_succ >= eff_count) ? '0 : in_succ;
                  end
               end
            end
         end
         ST_DRAIN: begin
            // The RAM holds the payload of next_exp_ff, read in the previous step.
            if (out_free) begin
               rsp_valid_in                       = 1'b1;
               rsp_id_in                          = next_exp_ff[ID_W-1:0];
               rsp_value_in                       = ram_rd_data;
               valid_in[next_exp_ff[ADDR_W-1:0]]  = 1'b0;
               if (dr_more) begin
                  rsp_last_in = 1'b0;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = dr_succ[ADDR_W-1:0];
                  next_exp_in = dr_succ;
               end else begin
                  rsp_last_in = 1'b1;
                  next_exp_in = (dr_succ >= eff_count) ? '0 : dr_succ;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write restarts the batch.
      if (csr_wr_en) begin
         batch_in    = csr_wdata;
         next_exp_in = '0;
         valid_in    = '0;
      end
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers and valid marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff     <= BATCH_RESET;
         next_exp_ff  <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         batch_ff     <= batch_in;
         next_exp_ff  <= next_exp_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      rsp_id_ff    <= rsp_id_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_value_ff, rsp_id_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: hdl/iorb_ram.sv
`default_nettype none

module iorb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/iorb_checker.sv
`default_nettype none

module iorb_checker
   import iorb_pkg::*;
#(
   parameter int DATA_W = 40
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [DATA_W-1:0] rsp_tdata,
   input wire logic              rsp_tlast
);

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // No new transaction is taken while a run is still being drained.
   a_no_accept_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input accepted during a drain run");

   // Results inside a run follow each other with consecutive ids.
   a_run_ids: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[ID_W-1:0] == $past(rsp_tdata[ID_W-1:0]) + ID_W'(1)))
      else $error("drain run skipped or repeated an id");

endmodule

bind in_order_reorder_buffer iorb_checker #(
   .DATA_W (DATA_W)
) u_iorb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
